### src/section_cycle_profiler_core_assert.svh
// Assertion macros for the section cycle profiler.
`ifndef SECTION_CYCLE_PROFILER_CORE_ASSERT_SVH
`define SECTION_CYCLE_PROFILER_CORE_ASSERT_SVH

// Checked on every rising edge outside reset.
`define SCP_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define SCP_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/scp_pkg.sv
// ----------------------------------------------------------------------------
// Section cycle profiler package
// Shared constants, field layouts and the control bundle between the
// controller and the datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package scp_pkg;

	localparam int SECTIONS_DEF = 5;
	localparam int BUCKETS      = 4;
	localparam int TIMER_W      = 16;
	localparam int COUNT_W      = 32;
	localparam int DIV_STEPS    = 32;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

	localparam logic [15:0] SANITY_RESET = 16'd50000;
	localparam logic [15:0] TARGET_RESET = 16'd500;
	localparam logic [2:0]  APPLY_RESET  = 3'd1;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 184;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [2:0] {
		KIND_START  = 3'd0,
		KIND_END    = 3'd1,
		KIND_FRAME  = 3'd2,
		KIND_RD_SEC = 3'd3,
		KIND_RD_BKT = 3'd4
	} kind_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SANITY = 2'd0,
		REG_TARGET = 2'd1,
		REG_APPLY  = 2'd2
	} reg_idx_t;

	// Input beat payload, last field in the lowest bits.
	typedef struct packed {
		logic        bucket_valid;
		logic [1:0]  bucket;
		logic [15:0] timer_value;
		logic [2:0]  section;
	} in_word_t;

	// Result beat payload, last field in the lowest bits.
	typedef struct packed {
		logic        any_rejects;
		logic [31:0] bucket_rejects;
		logic [31:0] rejects;
		logic [15:0] largest;
		logic [31:0] samples;
		logic [31:0] total;
		logic [15:0] average;
		logic        halted;
		logic        accepted;
		logic [15:0] elapsed;
	} out_word_t;

	typedef struct packed {
		logic capture;
		logic exec;
		logic div_step;
		logic load_out;
	} ctl_cmd_t;

	typedef struct packed {
		logic need_div;
	} dp_stat_t;

endpackage

`default_nettype wire

### src/scp_ctrl.sv
// ----------------------------------------------------------------------------
// Section cycle profiler controller
// Sequences capture, update, serial division and result hand-over.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	output logic                   m_tvalid,
	input  wire logic              m_tready,
	output scp_pkg::ctl_cmd_t      cmd,
	input  wire scp_pkg::dp_stat_t stat
);
	import scp_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_EXEC = 4'b0010,
		ST_DIV  = 4'b0100,
		ST_DONE = 4'b1000
	} state_t;

	state_t               state_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic                 out_valid_q;
	logic                 out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd.capture  = (state_q == ST_IDLE) && s_tvalid;
		cmd.exec     = (state_q == ST_EXEC);
		cmd.div_step = (state_q == ST_DIV);
		cmd.load_out = (state_q == ST_DONE) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					step_q  <= '0;
					state_q <= stat.need_div ? ST_DIV : ST_DONE;
				end
				ST_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### src/scp_datapath.sv
// ----------------------------------------------------------------------------
// Section cycle profiler datapath
// Per-section statistics, bucket reject counters, frame counter, settings,
// a serial restoring divider for the average and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scp_datapath #(
	parameter int SECTIONS = scp_pkg::SECTIONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire scp_pkg::ctl_cmd_t               cmd,
	output scp_pkg::dp_stat_t                    stat,
	input  wire logic [scp_pkg::IN_TDATA_W-1:0]  in_data,
	input  wire logic [2:0]                      in_kind,
	input  wire logic                            cfg_wr,
	input  wire logic [scp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [scp_pkg::CFG_DATA_W-1:0]  cfg_data,
	output logic [scp_pkg::OUT_TDATA_W-1:0]      out_data
);
	import scp_pkg::*;

	localparam int IDX_W = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;

	// Captured event
	logic [2:0]  kind_q;
	in_word_t    ev_q;

	// Settings
	logic [15:0] sanity_q;
	logic [15:0] target_q;
	logic [2:0]  apply_q;

	// Statistics
	logic [15:0] stamp_q   [SECTIONS];
	logic [31:0] sum_q     [SECTIONS];
	logic [31:0] cnt_q     [SECTIONS];
	logic [31:0] rej_q     [SECTIONS];
	logic [15:0] max_q     [SECTIONS];
	logic [31:0] bkt_rej_q [BUCKETS];
	logic [15:0] frames_q;
	logic        halt_q;

	// Result staging
	logic [15:0] res_elapsed_q;
	logic        res_acc_q;
	logic [31:0] res_total_q;
	logic [31:0] res_samples_q;
	logic [15:0] res_largest_q;
	logic [31:0] res_rejects_q;
	logic [31:0] res_bkt_q;

	// Divider
	logic [31:0] quo_q;
	logic [31:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] rem_shift;
	logic [32:0] rem_diff;

	logic [3:0]       sec_ext;
	logic [IDX_W-1:0] idx;
	logic             sec_ok;
	logic [15:0]      elapsed;
	logic             reject;
	logic [15:0]      frames_nx;
	logic             any_rej;
	logic [15:0]      average;
	out_word_t        res;
	kind_t            kind;

	assign kind      = kind_t'(kind_q);
	assign sec_ext   = {1'b0, ev_q.section};
	assign idx       = sec_ext[IDX_W-1:0];
	assign sec_ok    = {2'b00, ev_q.section} < 5'(SECTIONS);
	// At most one wrap of the down-counter: modular difference covers both cases.
	assign elapsed   = stamp_q[idx] - ev_q.timer_value;
	assign reject    = elapsed > sanity_q;
	assign frames_nx = frames_q + 16'd1;

	assign stat.need_div = (kind == KIND_RD_SEC) && sec_ok && (cnt_q[idx] != 32'd0);

	always_comb begin
		any_rej = 1'b0;
		for (int i = 0; i < SECTIONS; i++) begin
			any_rej = any_rej | (rej_q[i] != 32'd0);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= in_kind;
			ev_q   <= in_word_t'(in_data[$bits(in_word_t)-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sanity_q <= SANITY_RESET;
			target_q <= TARGET_RESET;
			apply_q  <= APPLY_RESET;
			frames_q <= '0;
			halt_q   <= 1'b0;
			for (int i = 0; i < SECTIONS; i++) begin
				stamp_q[i] <= '0;
				sum_q[i]   <= '0;
				cnt_q[i]   <= '0;
				rej_q[i]   <= '0;
				max_q[i]   <= '0;
			end
			for (int b = 0; b < BUCKETS; b++) begin
				bkt_rej_q[b] <= '0;
			end
		end else begin
			if (cfg_wr) begin
				unique case (cfg_index)
					REG_SANITY: sanity_q <= cfg_data;
					REG_TARGET: target_q <= cfg_data;
					REG_APPLY:  apply_q  <= cfg_data[2:0];
					default: begin
					end
				endcase
			end
			if (cmd.exec) begin
				unique case (kind)
					KIND_START: begin
						if (!halt_q && sec_ok) begin
							stamp_q[idx] <= ev_q.timer_value;
						end
					end
					KIND_END: begin
						if (!halt_q && sec_ok) begin
							if (reject) begin
								rej_q[idx] <= rej_q[idx] + 32'd1;
								if ((ev_q.section == apply_q) && ev_q.bucket_valid) begin
									bkt_rej_q[ev_q.bucket] <= bkt_rej_q[ev_q.bucket] + 32'd1;
								end
							end else begin
								sum_q[idx] <= sum_q[idx] + {16'd0, elapsed};
								cnt_q[idx] <= cnt_q[idx] + 32'd1;
								if (elapsed > max_q[idx]) begin
									max_q[idx] <= elapsed;
								end
							end
						end
					end
					KIND_FRAME: begin
						if (!halt_q) begin
							frames_q <= frames_nx;
							if (frames_nx >= target_q) begin
								halt_q <= 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Result fields other than the average are settled in the update cycle.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_elapsed_q <= '0;
			res_acc_q     <= 1'b0;
			res_total_q   <= '0;
			res_samples_q <= '0;
			res_largest_q <= '0;
			res_rejects_q <= '0;
			res_bkt_q     <= '0;
			case (kind)
				KIND_END: begin
					if (!halt_q && sec_ok) begin
						res_elapsed_q <= elapsed;
						res_acc_q     <= !reject;
					end
				end
				KIND_RD_SEC: begin
					if (sec_ok) begin
						res_total_q   <= sum_q[idx];
						res_samples_q <= cnt_q[idx];
						res_largest_q <= max_q[idx];
						res_rejects_q <= rej_q[idx];
					end
				end
				KIND_RD_BKT: begin
					res_bkt_q <= bkt_rej_q[ev_q.bucket];
				end
				default: begin
				end
			endcase
		end
	end

	// Restoring division, one quotient bit per cycle; the quotient register
	// starts out holding the dividend and shifts it out as bits come in.
	assign rem_shift = {rem_q, quo_q[31]};
	assign rem_diff  = rem_shift - {1'b0, dvs_q};

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			quo_q <= stat.need_div ? sum_q[idx] : 32'd0;
			rem_q <= '0;
			dvs_q <= cnt_q[idx];
		end else if (cmd.div_step) begin
			if (!rem_diff[32]) begin
				rem_q <= rem_diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= rem_shift[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign average = (quo_q[31:16] != 16'd0) ? 16'hFFFF : quo_q[15:0];

	always_comb begin
		res.elapsed        = res_elapsed_q;
		res.accepted       = res_acc_q;
		res.halted         = halt_q;
		res.average        = average;
		res.total          = res_total_q;
		res.samples        = res_samples_q;
		res.largest        = res_largest_q;
		res.rejects        = res_rejects_q;
		res.bucket_rejects = res_bkt_q;
		res.any_rejects    = any_rej;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_data <= OUT_TDATA_W'(res);
		end
	end

endmodule

`default_nettype wire

### src/section_cycle_profiler_core.sv
// ----------------------------------------------------------------------------
// Section cycle profiler
// Per-section cycle statistics from down-counting timer samples, with
// frame-count halt and read-back of statistics and bucket reject counts.
// ----------------------------------------------------------------------------
//  Channel  Dir  Signals                            Carries
//  s_*      in   s_tvalid s_tready s_tdata s_tuser  events
//  m_*      out  m_tvalid m_tready m_tdata          one result per event
//  cfg_*    in   cfg_valid cfg_ready cfg_index      settings writes
//                cfg_data
//
// An event goes from its input beat through capture, update and the result
// register to its result beat; a section read with a nonzero sample count
// also runs the bit-serial divider, one quotient bit per cycle, for the average.
// One event is in work at a time; the next input beat is taken the cycle
// after the result is registered, even if that result still waits.
// Reset clears every counter and returns the settings to their defaults.
// Settings writes are always taken.
`default_nettype none

module section_cycle_profiler_core #(
	parameter int SECTIONS = scp_pkg::SECTIONS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// section, timer_value, bucket, bucket_valid, zero pad
	input  wire logic [scp_pkg::IN_TDATA_W-1:0]  s_tdata,
	// kind
	input  wire logic [2:0]                      s_tuser,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// elapsed, accepted, halted, average, total, samples, largest, rejects,
	// bucket_rejects, any_rejects, zero pad
	output logic [scp_pkg::OUT_TDATA_W-1:0]      m_tdata,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [scp_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [scp_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import scp_pkg::*;

	ctl_cmd_t cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	scp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.stat     (stat)
	);

	scp_datapath #(
		.SECTIONS (SECTIONS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.in_data   (s_tdata),
		.in_kind   (s_tuser),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.out_data  (m_tdata)
	);

endmodule

`default_nettype wire

### src/scp_checker.sv
// ----------------------------------------------------------------------------
// Section cycle profiler port checker
// Watches the top level's ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "section_cycle_profiler_core_assert.svh"

module scp_checker (
	input wire logic                            clk,
	input wire logic                            arst_n,
	input wire logic                            s_tvalid,
	input wire logic                            s_tready,
	input wire logic                            m_tvalid,
	input wire logic                            m_tready,
	input wire logic [scp_pkg::OUT_TDATA_W-1:0] m_tdata,
	input wire logic                            cfg_ready
);

	// A stalled result beat keeps its payload.
	`SCP_ASSERT(a_out_hold, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata), "result beat changed while stalled")

	// Only one event is in work: an input beat closes the input side.
	`SCP_ASSERT(a_one_event, s_tvalid && s_tready |=> !s_tready, "input taken while an event is in work")

	// A result never appears in the cycle right after its input beat.
	`SCP_ASSERT(a_min_latency, $rose(m_tvalid) |-> !$past(s_tvalid && s_tready), "result too early")

	// Registering a result reopens the input side.
	`SCP_ASSERT(a_reopen, $rose(m_tvalid) |-> s_tready, "input side not reopened with new result")

	// Settings writes are never held off.
	`SCP_ASSERT_ALWAYS(a_cfg_open, cfg_ready, "settings write held off")

endmodule

bind section_cycle_profiler_core scp_checker u_scp_checker (.*);

`default_nettype wire
